// ===== design/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants and register indexes for the sample format converter.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_FMT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BITS      = 2'd3;

  localparam logic [31:0] F32_INF_EXP = 32'h7F80_0000;
  localparam logic [15:0] F16_INF_EXP = 16'h7C00;

  // converter settings handed to the datapath
  typedef struct packed {
    logic       direction;
    logic       float_fmt;
    logic [2:0] bytes;
    logic [4:0] bits;
  } cfg_t;

endpackage

// ===== design/sfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfc_stream_if
// Valid/ready channel carrying a sample and a status bit.
// ----------------------------------------------------------------------------
interface sfc_stream_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        status;

  modport source (output valid, output sample, output status, input ready);
  modport sink (input valid, input sample, input status, output ready);
endinterface

// ===== design/sfc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sfc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/sfc_convert.sv =====
// ----------------------------------------------------------------------------
// sfc_convert
// Combinational conversion of one sample between stored format and float32.
// ----------------------------------------------------------------------------
module sfc_convert
  import sfc_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] sample_i,
  output logic [31:0] sample_o,
  output logic        status_o
);

  // half to single
  function automatic logic [31:0] h2s(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] lz;
    logic [10:0] mn;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    mn = 11'({1'b0, m} << (lz + 4'd1));
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'(8'd113 - 8'(lz) - 8'd1), mn[9:0], 13'd0};
    end else if (e == 5'd31) begin
      r = {h[15], 8'hFF, m, 13'd0};
    end else begin
      r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // single to half
  function automatic logic [15:0] s2h(input logic [31:0] f);
    logic [7:0] fe;
    logic [9:0] m;
    logic signed [9:0] e;
    logic [10:0] sig;
    logic [15:0] r;
    fe = f[30:23];
    m = f[22:13];
    e = $signed({2'b00, fe}) - 10'sd112;
    sig = {1'b1, m};
    if (fe == 8'hFF) begin
      if (f[22:0] != 23'd0) r = {f[31], F16_INF_EXP[14:10], (m != 10'd0) ? m : 10'd1};
      else r = {f[31], F16_INF_EXP[14:0]};
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) r = {f[31], 15'd0};
      else r = {f[31], 4'd0, 11'(sig >> 4'(10'sd1 - e))};
    end else if (e >= 10'sd31) begin
      r = {f[31], F16_INF_EXP[14:0]};
    end else begin
      r = {f[31], e[4:0], m};
    end
    return r;
  endfunction

  // unsigned to single, round to nearest even
  function automatic logic [31:0] u2s(input logic [31:0] v);
    logic [4:0] p;
    logic [4:0] sh;
    logic [31:0] q, rem, half, mask;
    logic [31:0] r;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    if (v == 32'd0) begin
      r = 32'd0;
    end else begin
      if (p <= 5'd23) begin
        q = v << (5'd23 - p);
      end else begin
        sh = p - 5'd23;
        mask = (32'd1 << sh) - 32'd1;
        rem = v & mask;
        half = 32'd1 << (sh - 5'd1);
        q = v >> sh;
        if (rem > half || (rem == half && q[0])) q = q + 32'd1;
      end
      r = ({19'd0, 8'(8'(p) + 8'd127), 5'd0} << 18) + (q - 32'h0080_0000);
    end
    return r;
  endfunction

  // single to unsigned, clamp and round half to even
  function automatic logic [31:0] s2u(input logic [31:0] f, input logic [4:0] bits);
    logic [31:0] maxv, sig, q, rem, half;
    logic [7:0] fe, sh;
    logic [31:0] r;
    maxv = (32'd1 << bits) - 32'd1;
    fe = f[30:23];
    sig = {8'd0, 1'b1, f[22:0]};
    q = 32'd0;
    if ((fe == 8'hFF && f[22:0] != 23'd0) || f[31] || fe == 8'd0) begin
      r = 32'd0;
    end else if ({1'b0, fe} >= 9'd127 + {4'd0, bits}) begin
      r = maxv;
    end else begin
      if (fe >= 8'd150) begin
        q = sig << 5'(fe - 8'd150);
      end else begin
        sh = 8'd150 - fe;
        if (sh >= 8'd25) begin
          q = 32'd0;
        end else begin
          rem = sig & ((32'd1 << sh[4:0]) - 32'd1);
          half = 32'd1 << (sh[4:0] - 5'd1);
          q = sig >> sh[4:0];
          if (rem > half || (rem == half && q[0])) q = q + 32'd1;
        end
      end
      r = (q > maxv) ? maxv : q;
    end
    return r;
  endfunction

  logic [31:0] mask;
  logic [31:0] r;
  logic        bad;

  // format select
  always_comb begin
    unique case (cfg.bytes)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    r = 32'd0;
    bad = 1'b0;
    if (cfg.float_fmt) begin
      if (cfg.bytes == 3'd4) r = sample_i;
      else if (cfg.bytes == 3'd2)
        r = cfg.direction ? {16'd0, s2h(sample_i)} : h2s(sample_i[15:0]);
      else bad = 1'b1;
    end else if (cfg.bytes != 3'd1 && cfg.bytes != 3'd2 && cfg.bytes != 3'd4) begin
      bad = 1'b1;
    end else if (!cfg.direction) begin
      r = u2s(sample_i & mask);
    end else if (cfg.bits == 5'd0) begin
      bad = 1'b1;
    end else begin
      r = s2u(sample_i, cfg.bits) & mask;
    end
    sample_o = bad ? 32'd0 : r;
    status_o = bad;
  end

endmodule

// ===== design/sample_format_converter.sv =====
// ----------------------------------------------------------------------------
// sample_format_converter
// Converts video samples between stored format and float32.
// ----------------------------------------------------------------------------
// the combinational conversion result is captured in the result register
// throughput: one sample per cycle while the sink accepts, set by the single registered conversion
// stage; the output register holds a result while the sink stalls
// reset: synchronous active-low; settings return to integer, 1 byte, 8 bits
module sample_format_converter
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sfc_stream_if.sink   in_ch,
  sfc_stream_if.source out_ch,
  sfc_cfg_if.sink      cfg_ch
);

  cfg_t        cfg_r;
  logic        vld_r;
  logic [31:0] smp_r;
  logic        sts_r;
  logic [31:0] smp_nxt;
  logic        sts_nxt;
  logic        adv;

  assign cfg_ch.ready = 1'b1;
  assign adv = !vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{direction: 1'b0, float_fmt: 1'b0, bytes: 3'd1, bits: 5'd8};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DIRECTION: cfg_r.direction <= cfg_ch.data[0];
        REG_FLOAT_FMT: cfg_r.float_fmt <= cfg_ch.data[0];
        REG_BYTES:     cfg_r.bytes     <= cfg_ch.data[2:0];
        REG_BITS:      cfg_r.bits      <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  sfc_convert u_conv (
    .cfg      (cfg_r),
    .sample_i (in_ch.sample),
    .sample_o (smp_nxt),
    .status_o (sts_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      smp_r <= smp_nxt;
      sts_r <= sts_nxt;
    end
  end

  assign out_ch.valid  = vld_r;
  assign out_ch.sample = smp_r;
  assign out_ch.status = sts_r;

endmodule
